### src/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// Types, constants and helper functions shared by the event scheduler.
// ----------------------------------------------------------------------------
package cbs_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int TRIG_BITS   = 8;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CYC_W       = 64;
	localparam int Q_DEPTH     = 2;

	typedef logic [CYC_W-1:0]       cyc_t;
	typedef logic [TRIG_BITS-1:0]   trig_t;
	typedef logic [TABLE_DEPTH-1:0] slot_vec_t;
	typedef logic [IDX_W-1:0]       idx_t;

	typedef enum logic [2:0] {
		CMD_TICK          = 3'd0,
		CMD_SET_ABS       = 3'd1,
		CMD_SET_REL       = 3'd2,
		CMD_CLR_TRIGGER   = 3'd3,
		CMD_CLR_CYCLE     = 3'd4,
		CMD_REASSIGN      = 3'd5,
		CMD_CLR_CURRENT   = 3'd6,
		CMD_UNKNOWN       = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		RES_FIRED    = 2'd0,
		RES_ACCEPTED = 2'd1,
		RES_REJECTED = 2'd2
	} res_t;

	typedef struct packed {
		cmd_t  cmd;
		cyc_t  cv;
		cyc_t  nc;
		trig_t trig;
	} entry_t;

	function automatic slot_vec_t lowest_bit(input slot_vec_t v);
		return v & (~v + slot_vec_t'(1));
	endfunction

	function automatic idx_t onehot_idx(input slot_vec_t v);
		idx_t r;
		r = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (v[i])
				r = r | idx_t'(i);
		end
		return r;
	endfunction

endpackage

### src/cycle_break_scheduler.sv
// ----------------------------------------------------------------------------
// cycle_break_scheduler
// Cycle counter with a table of pending events fired on tick commands.
// ----------------------------------------------------------------------------
// Commands enter a two-entry queue and are executed one at a time, each passing
// through a compare state and an execute state. A tick that fires nothing gives
// no result; every other command gives one result; a firing tick gives one
// result per fired event. The compare pass over all sixteen table slots is
// registered before the command updates the table.
module cycle_break_scheduler import cbs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [63:0] cycle_value,
	input  logic [63:0] target_cycle,
	input  logic [7:0]  trigger_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  fired_trigger,
	output logic [63:0] event_cycle,
	output logic        last_of_run
);

	logic   push, q_full, pop, q_not_empty;
	entry_t push_entry, pop_entry;

	cbs_front u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.cycle_value (cycle_value),
		.target_cycle(target_cycle),
		.trigger_id  (trigger_id),
		.push        (push),
		.push_entry  (push_entry),
		.q_full      (q_full)
	);

	cbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (q_full),
		.pop       (pop),
		.pop_entry (pop_entry),
		.not_empty (q_not_empty)
	);

	cbs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_entry      (pop_entry),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.fired_trigger(fired_trigger),
		.event_cycle  (event_cycle),
		.last_of_run  (last_of_run)
	);

endmodule

### src/cbs_front.sv
// ----------------------------------------------------------------------------
// cbs_front
// Accepts commands, casts the command code and passes the trigger id through.
// ----------------------------------------------------------------------------
module cbs_front import cbs_pkg::*; (
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [63:0] cycle_value,
	input  logic [63:0] target_cycle,
	input  logic [7:0]  trigger_id,
	output logic        push,
	output entry_t      push_entry,
	input  logic        q_full
);

	assign in_stall        = q_full;
	assign push            = in_valid && !q_full;
	assign push_entry.cmd  = cmd_t'(command);
	assign push_entry.cv   = cycle_value;
	assign push_entry.nc   = target_cycle;
	assign push_entry.trig = trigger_id[TRIG_BITS-1:0];

endmodule

### src/cbs_queue.sv
// ----------------------------------------------------------------------------
// cbs_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module cbs_queue import cbs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output entry_t pop_entry,
	output logic   not_empty
);

	entry_t                   mem_q [Q_DEPTH];
	logic [$clog2(Q_DEPTH)-1:0] wr_q, rd_q;
	logic [$clog2(Q_DEPTH):0]   cnt_q;

	assign full      = (cnt_q == ($clog2(Q_DEPTH)+1)'(Q_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_entry = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### src/cbs_back.sv
// ----------------------------------------------------------------------------
// cbs_back
// Holds the cycle counter and the event table and carries out commands.
// ----------------------------------------------------------------------------
module cbs_back import cbs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_not_empty,
	input  entry_t      q_entry,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  fired_trigger,
	output logic [63:0] event_cycle,
	output logic        last_of_run
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CMP  = 4'b0010,
		ST_EXEC = 4'b0100,
		ST_FIRE = 4'b1000
	} state_t;

	state_t    state_q;
	entry_t    cmd_q;
	cyc_t      cur_q;
	cyc_t      tgt_q;
	logic      past_q;
	slot_vec_t valid_q, fire_q;
	slot_vec_t m_cur_eq_q, m_cur_lt_q, m_dup_q, m_pair_q, m_trig_q, m_cv_q;
	cyc_t      slot_cycle_q [TABLE_DEPTH];
	trig_t     slot_trig_q  [TABLE_DEPTH];

	logic      out_valid_q, last_q;
	res_t      kind_q;
	trig_t     otrig_q;
	cyc_t      ocyc_q;

	cyc_t      tgt;
	slot_vec_t m_cur_eq, m_cur_lt, m_dup, m_pair, m_trig, m_cv;
	logic      can_load;
	slot_vec_t fire_bit, ins_free, ins_bit, rea_valid;
	idx_t      fire_idx, ins_idx;

	assign pop      = (state_q == ST_IDLE) && q_not_empty;
	assign can_load = !out_valid_q || !out_stall;
	assign tgt      = (cmd_q.cmd == CMD_SET_REL) ? cur_q + cmd_q.cv : cmd_q.cv;

	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			m_cur_eq[i] = valid_q[i] && (slot_cycle_q[i] == cur_q);
			m_cur_lt[i] = valid_q[i] && (slot_cycle_q[i] < cur_q);
			m_dup[i]    = valid_q[i] && (slot_cycle_q[i] == tgt)
				&& (slot_trig_q[i] == cmd_q.trig);
			m_pair[i]   = valid_q[i] && (slot_cycle_q[i] == cmd_q.cv)
				&& (slot_trig_q[i] == cmd_q.trig);
			m_trig[i]   = valid_q[i] && (slot_trig_q[i] == cmd_q.trig);
			m_cv[i]     = valid_q[i] && (slot_cycle_q[i] == cmd_q.cv);
		end
	end

	assign fire_bit  = lowest_bit(fire_q);
	assign fire_idx  = onehot_idx(fire_bit);
	assign rea_valid = valid_q & ~m_pair_q;
	assign ins_free  = (cmd_q.cmd == CMD_REASSIGN) ? ~rea_valid : ~valid_q;
	assign ins_bit   = lowest_bit(ins_free);
	assign ins_idx   = onehot_idx(ins_bit);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_not_empty)
			cmd_q <= q_entry;
		if (state_q == ST_CMP) begin
			tgt_q      <= tgt;
			past_q     <= (tgt <= cur_q);
			m_cur_eq_q <= m_cur_eq;
			m_cur_lt_q <= m_cur_lt;
			m_dup_q    <= m_dup;
			m_pair_q   <= m_pair;
			m_trig_q   <= m_trig;
			m_cv_q     <= m_cv;
		end
		if (state_q == ST_EXEC && can_load) begin
			if ((cmd_q.cmd == CMD_SET_ABS || cmd_q.cmd == CMD_SET_REL)
					&& !past_q && m_dup_q == '0 && ins_free != '0) begin
				slot_cycle_q[ins_idx] <= tgt_q;
				slot_trig_q[ins_idx]  <= cmd_q.trig;
			end else if (cmd_q.cmd == CMD_REASSIGN && ins_free != '0) begin
				slot_cycle_q[ins_idx] <= cmd_q.nc;
				slot_trig_q[ins_idx]  <= cmd_q.trig;
			end
		end
		if (can_load) begin
			if (state_q == ST_FIRE) begin
				kind_q  <= RES_FIRED;
				otrig_q <= slot_trig_q[fire_idx];
				ocyc_q  <= cur_q;
				last_q  <= ((fire_q & ~fire_bit) == '0);
			end else if (state_q == ST_EXEC) begin
				otrig_q <= cmd_q.trig;
				last_q  <= 1'b1;
				kind_q  <= RES_ACCEPTED;
				unique case (cmd_q.cmd)
					CMD_SET_ABS, CMD_SET_REL: begin
						ocyc_q <= tgt_q;
						if (past_q || m_dup_q != '0 || ins_free == '0)
							kind_q <= RES_REJECTED;
					end
					CMD_CLR_TRIGGER: ocyc_q <= '0;
					CMD_CLR_CYCLE:   ocyc_q <= cmd_q.cv;
					CMD_REASSIGN: begin
						ocyc_q <= cmd_q.nc;
						if (ins_free == '0)
							kind_q <= RES_REJECTED;
					end
					CMD_CLR_CURRENT: ocyc_q <= cur_q;
					default: begin
						ocyc_q <= '0;
						kind_q <= RES_REJECTED;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			valid_q     <= '0;
			fire_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_not_empty)
						state_q <= ST_CMP;
				end
				ST_CMP: state_q <= ST_EXEC;
				ST_EXEC: begin
					if (cmd_q.cmd == CMD_TICK) begin
						if (m_cur_eq_q != '0 && m_cur_lt_q == '0) begin
							fire_q  <= m_cur_eq_q;
							state_q <= ST_FIRE;
						end else begin
							cur_q   <= cur_q + 1'b1;
							state_q <= ST_IDLE;
						end
					end else if (can_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						unique case (cmd_q.cmd)
							CMD_SET_ABS, CMD_SET_REL: begin
								if (!past_q && m_dup_q == '0 && ins_free != '0)
									valid_q <= valid_q | ins_bit;
							end
							CMD_CLR_TRIGGER: valid_q <= valid_q & ~m_trig_q;
							CMD_CLR_CYCLE:   valid_q <= valid_q & ~m_cv_q;
							CMD_REASSIGN:    valid_q <= rea_valid | ins_bit;
							CMD_CLR_CURRENT: valid_q <= valid_q & ~(m_cur_eq_q & m_trig_q);
							default:         valid_q <= valid_q;
						endcase
					end
				end
				ST_FIRE: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						valid_q     <= valid_q & ~fire_bit;
						fire_q      <= fire_q & ~fire_bit;
						if ((fire_q & ~fire_bit) == '0) begin
							cur_q   <= cur_q + 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign fired_trigger = 8'(otrig_q);
	assign event_cycle   = ocyc_q;
	assign last_of_run   = last_q;

	a_fire_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIRE |-> fire_q != '0)
		else $error("fire set empty while firing");
	a_fire_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIRE |-> (fire_q & ~valid_q) == '0)
		else $error("firing a free slot");
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> fire_q == '0)
		else $error("fire set left over");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for cycle_break_scheduler
// Drives directed and random command sequences with bursty valid and with
// patterned or random stall, predicts every result with a behavioral copy of
// the event table, and checks each output transfer in order.
// ----------------------------------------------------------------------------

module tb;
	import cbs_pkg::*;

	class event_scoreboard;
		typedef struct {
			res_t  kind;
			trig_t trig;
			cyc_t  cyc;
			logic  last;
		} result_t;

		cyc_t    now_cycle;
		cyc_t    earliest;
		logic    busy [cbs_pkg::TABLE_DEPTH];
		cyc_t    at_cycle [cbs_pkg::TABLE_DEPTH];
		trig_t   owner [cbs_pkg::TABLE_DEPTH];
		result_t pending_results [$];
		int      errors;

		function new();
			now_cycle = '0;
			earliest = '1;
			foreach (busy[i]) busy[i] = 1'b0;
			errors = 0;
		endfunction

		function void rescan();
			earliest = '1;
			foreach (busy[i])
				if (busy[i] && at_cycle[i] < earliest) earliest = at_cycle[i];
		endfunction

		function int free_slots();
			int n;
			n = 0;
			foreach (busy[i]) if (!busy[i]) n++;
			return n;
		endfunction

		function bit place(cyc_t c, trig_t t);
			foreach (busy[i]) begin
				if (!busy[i]) begin
					busy[i] = 1'b1;
					at_cycle[i] = c;
					owner[i] = t;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function bit schedule(cyc_t c, trig_t t);
			if (c <= now_cycle) return 1'b0;
			foreach (busy[i])
				if (busy[i] && at_cycle[i] == c && owner[i] == t) return 1'b0;
			return place(c, t);
		endfunction

		function void note_command(cmd_t cmd, cyc_t cv, cyc_t nc, trig_t t);
			result_t r;
			bit ok;
			cyc_t c;
			int first;
			ok = 1'b1;
			c = '0;
			if (cmd == CMD_TICK) begin
				first = pending_results.size();
				if (now_cycle == earliest) begin
					foreach (busy[i]) begin
						if (busy[i] && at_cycle[i] == now_cycle) begin
							r.kind = RES_FIRED;
							r.trig = owner[i];
							r.cyc = at_cycle[i];
							r.last = 1'b0;
							pending_results.push_back(r);
							busy[i] = 1'b0;
						end
					end
					rescan();
				end
				if (pending_results.size() > first)
					pending_results[pending_results.size()-1].last = 1'b1;
				now_cycle++;
				return;
			end
			case (cmd)
				CMD_SET_ABS: begin
					c = cv;
					ok = schedule(c, t);
				end
				CMD_SET_REL: begin
					c = now_cycle + cv;
					ok = schedule(c, t);
				end
				CMD_CLR_TRIGGER: foreach (busy[i]) if (busy[i] && owner[i] == t) busy[i] = 1'b0;
				CMD_CLR_CYCLE: begin
					foreach (busy[i]) if (busy[i] && at_cycle[i] == cv) busy[i] = 1'b0;
					c = cv;
				end
				CMD_REASSIGN: begin
					foreach (busy[i])
						if (busy[i] && at_cycle[i] == cv && owner[i] == t) busy[i] = 1'b0;
					ok = place(nc, t);
					c = nc;
				end
				CMD_CLR_CURRENT: begin
					foreach (busy[i])
						if (busy[i] && at_cycle[i] == now_cycle && owner[i] == t)
							busy[i] = 1'b0;
					c = now_cycle;
				end
				default: ok = 1'b0;
			endcase
			rescan();
			r.kind = ok ? RES_ACCEPTED : RES_REJECTED;
			r.trig = t;
			r.cyc = c;
			r.last = 1'b1;
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [1:0] k, logic [7:0] t, logic [63:0] c, logic l);
			result_t e;
			if (pending_results.size() == 0) begin
				$error("unexpected result kind=%0d trigger=%0d cycle=%0d", k, t, c);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			if (k !== e.kind) begin
				$error("result_kind expected %0d actual %0d", e.kind, k);
				errors++;
			end
			if (t !== e.trig) begin
				$error("fired_trigger expected %0d actual %0d", e.trig, t);
				errors++;
			end
			if (c !== e.cyc) begin
				$error("event_cycle expected %0d actual %0d", e.cyc, c);
				errors++;
			end
			if (l !== e.last) begin
				$error("last_of_run expected %0d actual %0d", e.last, l);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  command;
	logic [63:0] cycle_value;
	logic [63:0] target_cycle;
	logic [7:0]  trigger_id;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  result_kind;
	logic [7:0]  fired_trigger;
	logic [63:0] event_cycle;
	logic        last_of_run;

	event_scoreboard board;
	int          cycle_count;
	int          burst_left;
	int          stall_phase;
	int          stall_mode;

	cycle_break_scheduler i_dut (.*);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(result_kind, fired_trigger, event_cycle, last_of_run);
		stall_phase <= stall_phase + 1;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= (stall_phase % 5) < 2;
			2: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ((stall_phase / 7) % 2) == 1;
		endcase
		if (stall_phase % 97 == 0) stall_mode <= $urandom_range(0, 3);
	end

	task automatic send(cmd_t cmd, logic [63:0] cv, logic [63:0] nc, logic [7:0] t);
		while (burst_left == 0) begin
			if ($urandom_range(0, 2) == 0) begin
				burst_left = $urandom_range(1, 12);
			end else begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end
		end
		in_valid <= 1'b1;
		command <= cmd;
		cycle_value <= cv;
		target_cycle <= nc;
		trigger_id <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_command(cmd, cv, nc, t);
		burst_left--;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] near_delay();
		return 64'($urandom_range(1, 12));
	endfunction

	initial begin
		cmd_t  c;
		logic [7:0] t;
		int    pick;
		board = new();
		burst_left = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_TICK;
		cycle_value = '0;
		target_cycle = '0;
		trigger_id = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(CMD_TICK, '0, '0, 8'd0);
		send(CMD_SET_ABS, '0, '0, 8'd1);
		send(CMD_SET_ABS, 64'd3, '0, 8'd0);
		send(CMD_SET_ABS, 64'd3, '0, 8'd0);
		send(CMD_SET_ABS, 64'd3, '0, 8'hFF);
		send(CMD_SET_REL, '0, '0, 8'd2);
		send(CMD_SET_REL, '1, '0, 8'd2);
		send(CMD_SET_REL, 64'd2, '1, 8'h55);
		send(CMD_SET_ABS, '1, '1, 8'hAA);
		send(CMD_TICK, '1, '1, 8'hFF);
		send(CMD_TICK, '0, '0, 8'd0);
		send(CMD_TICK, '0, '0, 8'd0);
		send(CMD_TICK, '0, '0, 8'd0);
		for (int i = 0; i < 17; i++) send(CMD_SET_ABS, 64'd10, '0, 8'(i));
		send(CMD_REASSIGN, 64'd10, 64'd20, 8'd3);
		send(CMD_CLR_TRIGGER, '1, '0, 8'd5);
		send(CMD_REASSIGN, 64'd10, 64'd2, 8'd4);
		send(CMD_CLR_CURRENT, '0, '0, 8'd4);
		send(CMD_CLR_CYCLE, 64'd2, '0, 8'd9);
		send(CMD_CLR_CYCLE, 64'd10, '0, 8'd9);
		send(CMD_UNKNOWN, '1, '1, 8'hFF);
		send(CMD_CLR_CYCLE, '1, '0, 8'd0);

		for (int n = 0; n < 230; n++) begin
			pick = $urandom_range(0, 99);
			t = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3));
			if (pick < 35) send(CMD_TICK, rand64(), rand64(), 8'($urandom()));
			else if (pick < 50) send(CMD_SET_REL, near_delay(), rand64(), t);
			else if (pick < 60)
				send(CMD_SET_ABS, board.now_cycle + near_delay() - 2, rand64(), t);
			else if (pick < 64) send(CMD_SET_ABS, rand64(), rand64(), t);
			else if (pick < 67) send(CMD_SET_REL, rand64(), rand64(), t);
			else if (pick < 72) send(CMD_CLR_TRIGGER, rand64(), rand64(), t);
			else if (pick < 77)
				send(CMD_CLR_CYCLE, board.now_cycle + near_delay(), rand64(), t);
			else if (pick < 85) begin
				if (board.earliest < board.now_cycle)
					send(CMD_CLR_CYCLE, board.earliest, rand64(), t);
				else
					send(CMD_REASSIGN, board.now_cycle + near_delay(),
						board.now_cycle + near_delay() - 1, t);
			end else if (pick < 92) send(CMD_CLR_CURRENT, rand64(), rand64(), t);
			else if (pick < 95) begin
				c = cmd_t'($urandom_range(0, 7));
				if (c == CMD_UNKNOWN) send(c, rand64(), rand64(), t);
				else send(CMD_UNKNOWN, rand64(), rand64(), t);
			end else begin
				for (int k = 0; k < 18; k++) begin
					if (board.earliest < board.now_cycle)
						send(CMD_CLR_CYCLE, board.earliest, '0, t);
					send(CMD_TICK, '0, '0, 8'd0);
				end
			end
		end

		in_valid <= 1'b0;
		while (board.pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0 && board.pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
